// ===== rtl/core/pca_pkg.sv =====
// Shared types and constants for the perpendicular cone axes core.
// No dependencies; the top level, pca_mul, pca_sqrt and pca_div refer to it by scoped names.
package pca_pkg;

  // Pipeline control distributed to every stage unit.
  typedef struct packed {
    logic adv;  // all stages move one place when high
  } pca_ctl_t;

  // Register stages inside one split multiplier.
  localparam int MUL_LAT = 2;

  // Divider stages beyond one per quotient bit (overflow check, saturate).
  localparam int DIV_XTRA_LAT = 2;

endpackage

// ===== rtl/core/perpendicular_cone_axes_core.sv =====
// Top level of the perpendicular cone axes core: squares, radicand, root, numerators, divide.
// Depends on pca_pkg, pca_mul, pca_sqrt and pca_div.
//
//   channel   direction  word                                          tuser
//   s_axis    in         mom_x, mom_y, mom_z                           -
//   m_axis    out        first_x, first_y, second_x, second_y, shared_z valid_res
//
// One word enters per cycle while the output buffer has room. Most of the latency
// comes from the root unit (one bit per stage over 2*COMP_WIDTH stages)
// and the divider (one quotient bit per stage plus two).
// A two-word output buffer holds finished results; the whole pipeline advances
// together while the buffer has room, so a stall on m_axis loses and repeats nothing.
// rst is synchronous: it clears the valid bits and the buffer count only.
// Values are fixed point with a common scale; the scale cancels and needs no setting.
module perpendicular_cone_axes_core #(
  parameter int COMP_WIDTH = 22
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // mom_x, mom_y, mom_z from the lowest bit up, zero fill
  input  logic [((3*COMP_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // first_x, first_y, second_x, second_y, shared_z from the lowest bit up, zero fill
  output logic [((5*COMP_WIDTH+7)/8)*8-1:0]       m_axis_tdata,
  // valid_res
  output logic                                    m_axis_tuser
);

  localparam int W       = COMP_WIDTH;
  localparam int OUT_TW  = ((5 * W + 7) / 8) * 8;
  localparam int MUL_LAT = pca_pkg::MUL_LAT;
  localparam int DIV_LAT = W + pca_pkg::DIV_XTRA_LAT;

  typedef struct packed {
    logic [W-1:0]   ax;
    logic [W-1:0]   ay;
    logic [W-1:0]   z;
    logic [2*W-1:0] a;
    logic [2*W-1:0] q;
    logic           xpos;
    logic           ypos;
    logic           tneg;
    logic           bad;
  } side_t;

  // signed-magnitude sum of -/+pm and -/+rm, returned as {neg, magnitude}
  function automatic logic [3*W+1:0] numer(input logic [3*W-1:0] pm, input logic pn,
                                           input logic [3*W-1:0] rm, input logic rn);
    logic [3*W:0] pe;
    logic [3*W:0] re;
    pe = {1'b0, pm};
    re = {1'b0, rm};
    if (pn == rn) begin
      numer = {pn, pe + re};
    end else if (pm >= rm) begin
      numer = {pn, pe - re};
    end else begin
      numer = {rn, re - pe};
    end
  endfunction

  pca_pkg::pca_ctl_t ctl;
  logic [1:0]        cnt;
  logic [1:0]        cnt_next;
  logic              push;
  logic              pop;

  // Advance everything while the output buffer is not full
  assign ctl.adv       = (cnt != 2'd2);
  assign s_axis_tready = ctl.adv;

  // Stage 1: capture the word
  logic         v1;
  logic [W-1:0] x1, y1, z1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ctl.adv) begin
      v1 <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      x1 <= s_axis_tdata[W-1:0];
      y1 <= s_axis_tdata[2*W-1:W];
      z1 <= s_axis_tdata[3*W-1:2*W];
    end
  end

  // Stage 2: magnitudes, squares, sign flags
  logic [W-1:0]   ax_c, ay_c, az_c;
  logic           v2;
  logic [W-1:0]   ax2, ay2, z2;
  logic [2*W-1:0] sx2, sy2, q2;
  logic           xpos2, ypos2, tneg2;

  assign ax_c = x1[W-1] ? (~x1 + 1'b1) : x1;
  assign ay_c = y1[W-1] ? (~y1 + 1'b1) : y1;
  assign az_c = z1[W-1] ? (~z1 + 1'b1) : z1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ctl.adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      ax2   <= ax_c;
      ay2   <= ay_c;
      z2    <= z1;
      sx2   <= ax_c * ax_c;
      sy2   <= ay_c * ay_c;
      q2    <= az_c * az_c;
      xpos2 <= !x1[W-1] && (x1 != '0);
      ypos2 <= !y1[W-1] && (y1 != '0);
      // x or y on the axis keeps t positive; otherwise t flips when x and y share a sign
      tneg2 <= (y1 != '0) && (x1 != '0) && (x1[W-1] == y1[W-1]);
    end
  end

  // Stage 3: transverse square A
  logic           v3;
  logic [W-1:0]   ax3, ay3, z3;
  logic [2*W-1:0] a3, q3;
  logic           xpos3, ypos3, tneg3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (ctl.adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      ax3   <= ax2;
      ay3   <= ay2;
      z3    <= z2;
      a3    <= sx2 + sy2;
      q3    <= q2;
      xpos3 <= xpos2;
      ypos3 <= ypos2;
      tneg3 <= tneg2;
    end
  end

  // Stage 4: radicand factors and the degenerate flag
  logic           v4;
  logic           bad_c;
  logic [2*W-1:0] d4, e4;
  side_t          side4;

  assign bad_c = (a3 == '0) || (a3 < q3);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (ctl.adv) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      d4         <= bad_c ? '0 : (a3 - q3);
      e4         <= a3 + q3;
      side4.ax   <= ax3;
      side4.ay   <= ay3;
      side4.z    <= z3;
      side4.a    <= a3;
      side4.q    <= q3;
      side4.xpos <= xpos3;
      side4.ypos <= ypos3;
      side4.tneg <= tneg3;
      side4.bad  <= bad_c;
    end
  end

  // Radicand (A-Q)*(A+Q)
  logic [4*W-1:0] de;

  pca_mul #(.AW(2*W), .BW(2*W)) u_mul_de (
    .clk (clk),
    .ctl (ctl),
    .a   (d4),
    .b   (e4),
    .p   (de)
  );

  logic  vd [MUL_LAT+1];
  side_t sd [MUL_LAT+1];

  assign vd[0] = v4;
  assign sd[0] = side4;

  for (genvar i = 0; i < MUL_LAT; i++) begin : g_de_dly
    always_ff @(posedge clk) begin
      if (rst) begin
        vd[i+1] <= 1'b0;
      end else if (ctl.adv) begin
        vd[i+1] <= vd[i];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.adv) begin
        sd[i+1] <= sd[i];
      end
    end
  end

  // Root S
  logic              sq_v;
  logic [2*W-1:0]    sq_root;
  logic [$bits(side_t)-1:0] sq_side;

  pca_sqrt #(.RW(4*W), .SW($bits(side_t))) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .in_valid  (vd[MUL_LAT]),
    .rad       (de),
    .side_in   (sd[MUL_LAT]),
    .out_valid (sq_v),
    .root      (sq_root),
    .side_out  (sq_side)
  );

  side_t sq_s;
  assign sq_s = sq_side;

  // Products X*Q, Y*Q, Y*S, X*S
  logic [3*W-1:0] xq, yq, ys, tm;

  pca_mul #(.AW(W), .BW(2*W)) u_mul_xq (
    .clk (clk), .ctl (ctl), .a (sq_s.ax), .b (sq_s.q), .p (xq)
  );
  pca_mul #(.AW(W), .BW(2*W)) u_mul_yq (
    .clk (clk), .ctl (ctl), .a (sq_s.ay), .b (sq_s.q), .p (yq)
  );
  pca_mul #(.AW(W), .BW(2*W)) u_mul_ys (
    .clk (clk), .ctl (ctl), .a (sq_s.ay), .b (sq_root), .p (ys)
  );
  pca_mul #(.AW(W), .BW(2*W)) u_mul_xs (
    .clk (clk), .ctl (ctl), .a (sq_s.ax), .b (sq_root), .p (tm)
  );

  logic  mv [MUL_LAT+1];
  side_t ms [MUL_LAT+1];

  assign mv[0] = sq_v;
  assign ms[0] = sq_s;

  for (genvar i = 0; i < MUL_LAT; i++) begin : g_prod_dly
    always_ff @(posedge clk) begin
      if (rst) begin
        mv[i+1] <= 1'b0;
      end else if (ctl.adv) begin
        mv[i+1] <= mv[i];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.adv) begin
        ms[i+1] <= ms[i];
      end
    end
  end

  // Combine: four signed numerators
  side_t          mt;
  logic           vc;
  logic [3*W+1:0] nfx, nfy, nsx, nsy;
  logic [2*W-1:0] ac;
  logic [W-1:0]   zc;
  logic           badc;

  assign mt = ms[MUL_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (ctl.adv) begin
      vc <= mv[MUL_LAT];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      nfx  <= numer(xq, mt.xpos, ys, 1'b0);
      nfy  <= numer(yq, mt.ypos, tm, mt.tneg);
      nsx  <= numer(xq, mt.xpos, ys, 1'b1);
      nsy  <= numer(yq, mt.ypos, tm, !mt.tneg);
      ac   <= mt.a;
      zc   <= mt.z;
      badc <= mt.bad;
    end
  end

  // Divide by A
  logic [W-1:0] r_fx, r_fy, r_sx, r_sy;

  pca_div #(.W(W)) u_div_fx (
    .clk (clk), .ctl (ctl), .num (nfx[3*W:0]), .neg (nfx[3*W+1]), .den (ac), .res (r_fx)
  );
  pca_div #(.W(W)) u_div_fy (
    .clk (clk), .ctl (ctl), .num (nfy[3*W:0]), .neg (nfy[3*W+1]), .den (ac), .res (r_fy)
  );
  pca_div #(.W(W)) u_div_sx (
    .clk (clk), .ctl (ctl), .num (nsx[3*W:0]), .neg (nsx[3*W+1]), .den (ac), .res (r_sx)
  );
  pca_div #(.W(W)) u_div_sy (
    .clk (clk), .ctl (ctl), .num (nsy[3*W:0]), .neg (nsy[3*W+1]), .den (ac), .res (r_sy)
  );

  logic         dv   [DIV_LAT+1];
  logic [W-1:0] dz   [DIV_LAT+1];
  logic         dbad [DIV_LAT+1];

  assign dv[0]   = vc;
  assign dz[0]   = zc;
  assign dbad[0] = badc;

  for (genvar i = 0; i < DIV_LAT; i++) begin : g_div_dly
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[i+1] <= 1'b0;
      end else if (ctl.adv) begin
        dv[i+1] <= dv[i];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.adv) begin
        dz[i+1]   <= dz[i];
        dbad[i+1] <= dbad[i];
      end
    end
  end

  // Result word: degenerate or negative radicand drops everything to zero
  logic         vq;
  logic         badq;
  logic [5*W:0] pw;

  assign vq   = dv[DIV_LAT];
  assign badq = dbad[DIV_LAT];
  assign pw   = badq ? '0 : {1'b1, dz[DIV_LAT], r_sy, r_sx, r_fy, r_fx};

  // Output buffer, two words deep
  logic [5*W:0] b0, b1;

  assign push = ctl.adv & vq;
  assign pop  = m_axis_tvalid & m_axis_tready;

  always_comb begin
    cnt_next = cnt;
    if (push && !pop) begin
      cnt_next = cnt + 2'd1;
    end else if (pop && !push) begin
      cnt_next = cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !pop) begin
      if (cnt == 2'd0) begin
        b0 <= pw;
      end else begin
        b1 <= pw;
      end
    end else if (pop && !push) begin
      b0 <= b1;
    end else if (pop && push) begin
      b0 <= pw;
    end
  end

  assign m_axis_tvalid = (cnt != 2'd0);
  assign m_axis_tdata  = OUT_TW'(b0[5*W-1:0]);
  assign m_axis_tuser  = b0[5*W];

endmodule

// ===== rtl/core/pca_mul.sv =====
// Two-stage unsigned multiplier built from four half-width partial products.
// Depends on pca_pkg for the pipeline control type.
module pca_mul #(
  parameter int AW = 22,
  parameter int BW = 44
) (
  input  logic               clk,
  input  pca_pkg::pca_ctl_t  ctl,
  input  logic [AW-1:0]      a,
  input  logic [BW-1:0]      b,
  output logic [AW+BW-1:0]   p
);

  localparam int HA = (AW + 1) / 2;
  localparam int HB = (BW + 1) / 2;
  localparam int PW = AW + BW;

  logic [HA-1:0]      a_lo;
  logic [AW-HA-1:0]   a_hi;
  logic [HB-1:0]      b_lo;
  logic [BW-HB-1:0]   b_hi;
  logic [HA+HB-1:0]   pll;
  logic [HA+BW-HB-1:0] plh;
  logic [AW-HA+HB-1:0] phl;
  logic [AW-HA+BW-HB-1:0] phh;
  logic [PW-1:0]      t0, t1, t2, t3;

  assign a_lo = a[HA-1:0];
  assign a_hi = a[AW-1:HA];
  assign b_lo = b[HB-1:0];
  assign b_hi = b[BW-1:HB];

  // First stage: partial products
  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      pll <= a_lo * b_lo;
      plh <= a_lo * b_hi;
      phl <= a_hi * b_lo;
      phh <= a_hi * b_hi;
    end
  end

  assign t0 = PW'(pll);
  assign t1 = PW'(plh) << HB;
  assign t2 = PW'(phl) << HA;
  assign t3 = PW'(phh) << (HA + HB);

  // Second stage: sum them
  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      p <= t0 + t1 + t2 + t3;
    end
  end

endmodule

// ===== rtl/core/pca_sqrt.sv =====
// Pipelined integer square root, one root bit per register stage.
// Depends on pca_pkg; carries a side vector and a valid bit along with the data.
module pca_sqrt #(
  parameter int RW = 88,
  parameter int SW = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  pca_pkg::pca_ctl_t  ctl,
  input  logic               in_valid,
  input  logic [RW-1:0]      rad,
  input  logic [SW-1:0]      side_in,
  output logic               out_valid,
  output logic [RW/2-1:0]    root,
  output logic [SW-1:0]      side_out
);

  localparam int K = RW / 2;

  logic          vld  [K+1];
  logic [K+1:0]  rem  [K+1];
  logic [K-1:0]  rt   [K+1];
  logic [RW-1:0] rd   [K+1];
  logic [SW-1:0] sd   [K+1];

  assign vld[0] = in_valid;
  assign rem[0] = '0;
  assign rt[0]  = '0;
  assign rd[0]  = rad;
  assign sd[0]  = side_in;

  for (genvar j = 0; j < K; j++) begin : g_stage
    logic [K+1:0] r_in;
    logic [K+1:0] trial;
    logic         ge;

    // bring down the next two radicand bits, try root bit one
    assign r_in  = {rem[j][K-1:0], rd[j][RW-1:RW-2]};
    assign trial = {rt[j], 2'b01};
    assign ge    = r_in >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (ctl.adv) begin
        vld[j+1] <= vld[j];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.adv) begin
        rem[j+1] <= ge ? (r_in - trial) : r_in;
        rt[j+1]  <= {rt[j][K-2:0], ge};
        rd[j+1]  <= rd[j] << 2;
        sd[j+1]  <= sd[j];
      end
    end
  end

  assign out_valid = vld[K];
  assign root      = rt[K];
  assign side_out  = sd[K];

endmodule

// ===== rtl/core/pca_div.sv =====
// Pipelined restoring divider with sign and saturation to a W-bit result.
// Depends on pca_pkg; one quotient bit per stage plus an overflow and a saturate stage.
module pca_div #(
  parameter int W = 22
) (
  input  logic               clk,
  input  pca_pkg::pca_ctl_t  ctl,
  input  logic [3*W:0]       num,
  input  logic               neg,
  input  logic [2*W-1:0]     den,
  output logic [W-1:0]       res
);

  localparam int NW = 3 * W + 1;
  localparam int DW = 2 * W;

  logic [NW-1:0] rem [W+1];
  logic [DW-1:0] dn  [W+1];
  logic          ng  [W+1];
  logic          ov  [W+1];
  logic [W-1:0]  qb  [W+1];
  logic          sat;

  // quotient of 2^W or more always saturates
  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      rem[0] <= num;
      dn[0]  <= den;
      ng[0]  <= neg;
      ov[0]  <= num >= {1'b0, den, {W{1'b0}}};
      qb[0]  <= '0;
    end
  end

  for (genvar j = 0; j < W; j++) begin : g_bit
    localparam int K = W - 1 - j;
    logic [NW-1:0] trial;
    logic          ge;

    assign trial = NW'(dn[j]) << K;
    assign ge    = rem[j] >= trial;

    always_ff @(posedge clk) begin
      if (ctl.adv) begin
        rem[j+1] <= ge ? (rem[j] - trial) : rem[j];
        dn[j+1]  <= dn[j];
        ng[j+1]  <= ng[j];
        ov[j+1]  <= ov[j];
        qb[j+1]  <= {qb[j][W-2:0], ge};
      end
    end
  end

  assign sat = ov[W] | (ng[W] ? (qb[W][W-1] & (|qb[W][W-2:0])) : qb[W][W-1]);

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      if (ng[W]) begin
        res <= sat ? {1'b1, {(W-1){1'b0}}} : (~qb[W] + 1'b1);
      end else begin
        res <= sat ? {1'b0, {(W-1){1'b1}}} : qb[W];
      end
    end
  end

endmodule

// ===== rtl/core/pca_checker.sv =====
// Port-level checks for the perpendicular cone axes core, bound to the top level.
// Depends only on the top level's ports.
module pca_checker #(
  parameter int COMP_WIDTH = 22
) (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 s_axis_tvalid,
  input logic                                 s_axis_tready,
  input logic [((3*COMP_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
  input logic                                 m_axis_tvalid,
  input logic                                 m_axis_tready,
  input logic [((5*COMP_WIDTH+7)/8)*8-1:0]    m_axis_tdata,
  input logic                                 m_axis_tuser
);

  // hold a stalled word
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output word changed while stalled");

  // undefined directions carry an all-zero word
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("invalid result with nonzero fields");

  // input stalls only behind a full buffer
  a_back: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no word pending");

  a_rst: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind perpendicular_cone_axes_core pca_checker #(.COMP_WIDTH(COMP_WIDTH)) u_pca_checker (.*);

// ===== dv/perpendicular_cone_axes_core_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the perpendicular cone axes core: watches both stream channels,
// computes the two perpendicular directions per input word and compares results.
module perpendicular_cone_axes_core_checker #(
  parameter int COMP_WIDTH = 22
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  input  logic                                 s_axis_tready,
  input  logic [((3*COMP_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
  input  logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  input  logic [((5*COMP_WIDTH+7)/8)*8-1:0]    m_axis_tdata,
  input  logic                                 m_axis_tuser,
  output int                                   fail_count,
  output int                                   pending
);

  typedef logic signed [COMP_WIDTH-1:0] comp_t;
  typedef logic signed [131:0] wide_t;

  typedef struct {
    comp_t first_x, first_y, second_x, second_y, shared_z;
    logic  dir_ok;
  } axes_t;

  axes_t axes_q[$];

  function automatic logic [63:0] isqrt(logic [127:0] v);
    logic [63:0] r, c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (128'(c) * 128'(c) <= v) r = c;
    end
    return r;
  endfunction

  // Truncating divide and saturate to the component range.
  function automatic comp_t div_sat(wide_t num, wide_t den);
    wide_t qv, hi, lo;
    qv = num / den;
    hi = (wide_t'(1) <<< (COMP_WIDTH - 1)) - 1;
    lo = -(wide_t'(1) <<< (COMP_WIDTH - 1));
    if (qv > hi) qv = hi;
    if (qv < lo) qv = lo;
    return comp_t'(qv);
  endfunction

  function automatic axes_t cone_axes(comp_t x, comp_t y, comp_t z);
    axes_t r;
    wide_t wx, wy, wz, a, q, s, ays, axs;
    wx = x; wy = y; wz = z;
    a = wx * wx + wy * wy;
    q = wz * wz;
    r = '{default: '0};
    // along the beam axis or negative radicand: nothing defined
    if (a == 0 || a < q) return r;
    s = wide_t'(isqrt(128'((a - q) * (a + q))));
    ays = (wy < 0 ? -wy : wy) * s;
    axs = (wx < 0 ? -wx : wx) * s;
    // y term is negative when x and y are nonzero and share a sign, else positive
    if (y != 0 && x != 0 && ((x > 0) == (y > 0))) axs = -axs;
    r.first_x  = div_sat(-wx * q + ays, a);
    r.first_y  = div_sat(-wy * q + axs, a);
    r.second_x = div_sat(-wx * q - ays, a);
    r.second_y = div_sat(-wy * q - axs, a);
    r.shared_z = z;
    r.dir_ok   = 1'b1;
    return r;
  endfunction

  assign pending = axes_q.size();

  always @(posedge clk) begin
    axes_t e;
    comp_t got[5];
    comp_t want[5];
    int    errs;
    errs = 0;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        axes_q.push_back(cone_axes(s_axis_tdata[0 +: COMP_WIDTH],
                                   s_axis_tdata[COMP_WIDTH +: COMP_WIDTH],
                                   s_axis_tdata[2*COMP_WIDTH +: COMP_WIDTH]));
      if (m_axis_tvalid && m_axis_tready) begin
        for (int i = 0; i < 5; i++) got[i] = m_axis_tdata[i*COMP_WIDTH +: COMP_WIDTH];
        if (axes_q.size() == 0) begin
          $display("%0t: result expected none actual %h", $time, m_axis_tdata);
          errs++;
        end else begin
          e = axes_q.pop_front();
          want = '{e.first_x, e.first_y, e.second_x, e.second_y, e.shared_z};
          for (int i = 0; i < 5; i++)
            if (got[i] !== want[i]) begin
              $display("%0t: field %0d expected %0d actual %0d", $time, i, want[i], got[i]);
              errs++;
            end
          if (m_axis_tuser !== e.dir_ok) begin
            $display("%0t: valid_res expected %b actual %b", $time, e.dir_ok, m_axis_tuser);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end

endmodule

// ===== dv/perpendicular_cone_axes_core_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the perpendicular cone axes core: clock, reset, stimulus and verdict.
// Depends on perpendicular_cone_axes_core and perpendicular_cone_axes_core_checker.
module perpendicular_cone_axes_core_tb;

  localparam int CW = 22;
  localparam int MAXV = (1 << (CW - 1)) - 1;
  localparam int MINV = -(1 << (CW - 1));

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [((3*CW+7)/8)*8-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [((5*CW+7)/8)*8-1:0] m_axis_tdata;
  logic m_axis_tuser;
  int   fail_count, pending;
  bit   send_idle = 1'b1;   // sender gaps enabled
  bit   recv_idle = 1'b1;   // receiver stalls enabled
  bit   hold_req  = 1'b0;   // ask receiver for one long hold-off

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  perpendicular_cone_axes_core #(.COMP_WIDTH(CW)) u_dut (.*);

  perpendicular_cone_axes_core_checker #(.COMP_WIDTH(CW)) u_chk (.*);

  // Drive one momentum word and hold it until the core takes it.
  task automatic send_mom(int x, int y, int z);
    @(negedge clk);
    while (send_idle && $urandom_range(99) < 30) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tdata  = '0;
    s_axis_tdata[0 +: CW]    = x[CW-1:0];
    s_axis_tdata[CW +: CW]   = y[CW-1:0];
    s_axis_tdata[2*CW +: CW] = z[CW-1:0];
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  function automatic int rand_comp(int lim);
    return $urandom_range(2 * lim) - lim;
  endfunction

  // Receiver: random stalls, plus one long hold-off counted here.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_axis_tready = 1'b0;
        repeat (400) @(negedge clk);
        hold_req = 1'b0;
      end
      m_axis_tready = !(recv_idle && $urandom_range(99) < 30);
    end
  end

  initial begin
    #5_000_000;
    $display("perpendicular_cone_axes_core_tb NOT OK");
    $finish;
  end

  initial begin
    int x, y, z, sel, m;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: on-axis, negative radicand, equal roots, axis cases, extremes
    send_mom(0, 0, 0);
    send_mom(0, 0, MAXV);
    send_mom(1, 1, 5);
    send_mom(3, 4, 5);
    send_mom(-3, 4, -5);
    send_mom(4096, 0, 0);
    send_mom(-4096, 0, 2048);
    send_mom(0, 4096, 2048);
    send_mom(0, -4096, -2048);
    send_mom(MINV, MINV, 0);
    send_mom(MAXV, MAXV, MAXV);
    send_mom(MINV, MAXV, MINV);
    send_mom(MAXV, MINV, 1);
    send_mom(MAXV, 0, MINV + 1);
    send_mom(0, MINV, MAXV);
    send_mom(1, 0, 0);
    send_mom(-1, -1, -1);
    send_mom(-1, 1, 0);
    send_mom(12345, -6789, 1000);
    send_mom(-200000, -300000, 150000);

    // pause until every result is back
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    wait (pending == 0);

    for (int n = 0; n < 1230; n++) begin
      if (n == 50) hold_req = 1'b1;
      send_idle = !(n >= 500 && n < 700);
      recv_idle = send_idle;
      sel = $urandom_range(99);
      m = (sel < 50) ? MAXV : (1 << $urandom_range(12));
      x = rand_comp(m);
      y = rand_comp(m);
      if (sel < 70) z = rand_comp((m > 2) ? m / 2 : 1);   // mostly well-defined
      else if (sel < 85) z = rand_comp(m);
      else if (sel < 92) z = rand_comp(MAXV);
      else begin
        z = rand_comp(MAXV);
        if (sel & 1) x = 0; else y = 0;
        if (sel == 99) begin x = 0; y = 0; end
      end
      send_mom(x, y, z);
    end
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    recv_idle = 1'b1;
    wait (pending == 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0)
      $display("perpendicular_cone_axes_core_tb OK");
    else
      $display("perpendicular_cone_axes_core_tb NOT OK");
    $finish;
  end

endmodule
